@@ sv/vtp_pkg.sv @@
`timescale 1ns / 1ps
package vtp_pkg;

	localparam int ANG_W     = 9;
	localparam int TRIG_FRAC = 14;
	localparam int TRIG_W    = 18;
	localparam int MSUM_W    = 2 * TRIG_W + 2;
	localparam int ADDR_W    = 3;

	typedef logic [ANG_W-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef trig_t mat_t [3][3];

	typedef struct packed {
		trig_t s;
		trig_t c;
	} sincos_t;

	typedef struct packed {
		logic vld;
		logic vis;
		logic negx;
		logic negy;
		logic satx;
		logic saty;
	} ctl_t;

	localparam logic [ADDR_W-1:0] REG_CAM_X  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_CAM_Y  = 3'd1;
	localparam logic [ADDR_W-1:0] REG_CAM_Z  = 3'd2;
	localparam logic [ADDR_W-1:0] REG_DIST   = 3'd3;
	localparam logic [ADDR_W-1:0] REG_CEN_X  = 3'd4;
	localparam logic [ADDR_W-1:0] REG_CEN_Y  = 3'd5;

	localparam angle_t DEG_90  = 9'd90;
	localparam angle_t DEG_180 = 9'd180;
	localparam angle_t DEG_270 = 9'd270;
	localparam angle_t DEG_360 = 9'd360;

	localparam trig_t TRIG_ONE  = 18'sd16384;
	localparam trig_t TRIG_ZERO = 18'sd0;
	localparam logic signed [MSUM_W-1:0] MSUM_HALF = MSUM_W'(1 << (TRIG_FRAC - 1));

	localparam logic [14:0] QSINE [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	function automatic angle_t wrap_angle(angle_t a);
		return (a >= DEG_360) ? angle_t'(a - DEG_360) : a;
	endfunction

	function automatic trig_t sine_of(angle_t d);
		angle_t idx;
		logic neg;
		trig_t mag;
		if (d <= DEG_90) begin
			idx = d;
			neg = 1'b0;
		end else if (d <= DEG_180) begin
			idx = angle_t'(DEG_180 - d);
			neg = 1'b0;
		end else if (d <= DEG_270) begin
			idx = angle_t'(d - DEG_180);
			neg = 1'b1;
		end else begin
			idx = angle_t'(DEG_360 - d);
			neg = 1'b1;
		end
		mag = trig_t'({3'b000, QSINE[idx[6:0]]});
		return neg ? trig_t'(-mag) : mag;
	endfunction

	function automatic sincos_t trig_of(angle_t a);
		angle_t w;
		sincos_t r;
		w = wrap_angle(a);
		r.s = sine_of(w);
		r.c = sine_of(wrap_angle(angle_t'(w + DEG_90)));
		return r;
	endfunction

	// cam selects the camera sign convention (negated sine)
	function automatic mat_t rot_x(sincos_t t, logic cam);
		mat_t m;
		trig_t s;
		s = cam ? trig_t'(-t.s) : t.s;
		m[0][0] = TRIG_ONE;  m[0][1] = TRIG_ZERO; m[0][2] = TRIG_ZERO;
		m[1][0] = TRIG_ZERO; m[1][1] = t.c;       m[1][2] = s;
		m[2][0] = TRIG_ZERO; m[2][1] = trig_t'(-s); m[2][2] = t.c;
		return m;
	endfunction

	function automatic mat_t rot_y(sincos_t t, logic cam);
		mat_t m;
		trig_t s;
		s = cam ? trig_t'(-t.s) : t.s;
		m[0][0] = t.c;       m[0][1] = TRIG_ZERO; m[0][2] = trig_t'(-s);
		m[1][0] = TRIG_ZERO; m[1][1] = TRIG_ONE;  m[1][2] = TRIG_ZERO;
		m[2][0] = s;         m[2][1] = TRIG_ZERO; m[2][2] = t.c;
		return m;
	endfunction

	function automatic mat_t rot_z(sincos_t t, logic cam);
		mat_t m;
		trig_t s;
		s = cam ? trig_t'(-t.s) : t.s;
		m[0][0] = t.c;         m[0][1] = s;         m[0][2] = TRIG_ZERO;
		m[1][0] = trig_t'(-s); m[1][1] = t.c;       m[1][2] = TRIG_ZERO;
		m[2][0] = TRIG_ZERO;   m[2][1] = TRIG_ZERO; m[2][2] = TRIG_ONE;
		return m;
	endfunction

	function automatic mat_t mat_mul(mat_t a, mat_t b);
		mat_t c;
		logic signed [MSUM_W-1:0] s;
		logic signed [MSUM_W-1:0] r;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				s = '0;
				for (int k = 0; k < 3; k++) begin
					s = s + MSUM_W'(a[i][k]) * MSUM_W'(b[k][j]);
				end
				r = (s + MSUM_HALF) >>> TRIG_FRAC;
				c[i][j] = r[TRIG_W-1:0];
			end
		end
		return c;
	endfunction

endpackage

@@ sv/vtp_front.sv @@
`timescale 1ns / 1ps
module vtp_front
	import vtp_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] vertex_x,
	input  logic signed [W-1:0] vertex_y,
	input  logic signed [W-1:0] vertex_z,
	input  angle_t              object_angle_x,
	input  angle_t              object_angle_y,
	input  angle_t              object_angle_z,
	input  logic signed [W-1:0] object_pos_x,
	input  logic signed [W-1:0] object_pos_y,
	input  logic signed [W-1:0] object_pos_z,
	input  angle_t              cam_x,
	input  angle_t              cam_y,
	input  angle_t              cam_z,
	output logic                out_valid,
	output logic signed [W-1:0] cx,
	output logic signed [W-1:0] cy,
	output logic signed [W-1:0] cz,
	output logic                vis
);

	localparam int PW = W + TRIG_W;
	localparam int SW = W + TRIG_W + 3;
	localparam logic signed [SW-1:0] HALF = SW'(1 << (TRIG_FRAC - 1));

	function automatic logic signed [W-1:0] sat_w(logic signed [SW-1:0] x);
		if (x[SW-1:W-1] == '0 || x[SW-1:W-1] == '1)
			return x[W-1:0];
		return x[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	logic [7:1] vld_s;

	logic signed [W-1:0] v_s1 [3], v_s2 [3], v_s3 [3];
	logic signed [W-1:0] p_s1 [3], p_s2 [3], p_s3 [3], p_s4 [3];
	sincos_t osc_s1 [3], csc_s1 [3];
	sincos_t oz_s2, cxa_s2;
	mat_t tobj_s2, tcam_s2, obj_s3, view_s3, view_s4, view_s5;
	logic signed [PW-1:0] prod_s4 [3][3];
	logic signed [W-1:0] w_s5 [3];
	logic signed [PW-1:0] prod_s6 [3][3];
	logic signed [W-1:0] c_s7 [3];

	logic signed [SW-1:0] sum5 [3];
	logic signed [SW-1:0] sum7 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum5[j] = ((SW'(prod_s4[0][j]) + SW'(prod_s4[1][j]) + SW'(prod_s4[2][j]) + HALF)
				>>> TRIG_FRAC) + SW'(p_s4[j]);
			sum7[j] = (SW'(prod_s6[0][j]) + SW'(prod_s6[1][j]) + SW'(prod_s6[2][j]) + HALF)
				>>> TRIG_FRAC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[6:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		v_s1[0] <= vertex_x;
		v_s1[1] <= vertex_y;
		v_s1[2] <= vertex_z;
		p_s1[0] <= object_pos_x;
		p_s1[1] <= object_pos_y;
		p_s1[2] <= object_pos_z;
		osc_s1[0] <= trig_of(object_angle_x);
		osc_s1[1] <= trig_of(object_angle_y);
		osc_s1[2] <= trig_of(object_angle_z);
		csc_s1[0] <= trig_of(cam_x);
		csc_s1[1] <= trig_of(cam_y);
		csc_s1[2] <= trig_of(cam_z);

		tobj_s2 <= mat_mul(rot_x(osc_s1[0], 1'b0), rot_y(osc_s1[1], 1'b0));
		tcam_s2 <= mat_mul(rot_z(csc_s1[2], 1'b1), rot_y(csc_s1[1], 1'b1));
		oz_s2   <= osc_s1[2];
		cxa_s2  <= csc_s1[0];
		v_s2    <= v_s1;
		p_s2    <= p_s1;

		obj_s3  <= mat_mul(tobj_s2, rot_z(oz_s2, 1'b0));
		view_s3 <= mat_mul(tcam_s2, rot_x(cxa_s2, 1'b1));
		v_s3    <= v_s2;
		p_s3    <= p_s2;

		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s4[i][j] <= PW'(v_s3[i]) * PW'(obj_s3[i][j]);
			end
		end
		view_s4 <= view_s3;
		p_s4    <= p_s3;

		for (int j = 0; j < 3; j++) begin
			w_s5[j] <= sat_w(sum5[j]);
		end
		view_s5 <= view_s4;

		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s6[i][j] <= PW'(w_s5[i]) * PW'(view_s5[i][j]);
			end
		end

		for (int j = 0; j < 3; j++) begin
			c_s7[j] <= sat_w(sum7[j]);
		end
	end

	assign out_valid = vld_s[7];
	assign cx = c_s7[0];
	assign cy = c_s7[1];
	assign cz = c_s7[2];
	assign vis = (c_s7[2] > 0);

endmodule

@@ sv/vtp_queue.sv @@
`timescale 1ns / 1ps
module vtp_queue #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic signed [W-1:0] in_cx,
	input  logic signed [W-1:0] in_cy,
	input  logic signed [W-1:0] in_cz,
	input  logic                in_vis,
	output logic                full,
	output logic                out_valid,
	output logic signed [W-1:0] out_cx,
	output logic signed [W-1:0] out_cy,
	output logic signed [W-1:0] out_cz,
	output logic                out_vis
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	logic signed [W-1:0] cx_q [DEPTH];
	logic signed [W-1:0] cy_q [DEPTH];
	logic signed [W-1:0] cz_q [DEPTH];
	logic                vis_q [DEPTH];
	logic [PTR_W-1:0]    wr_q, rd_q;
	logic [PTR_W:0]      cnt_q;
	logic                pop;

	// back end never stalls: drain whenever an entry is present
	assign pop       = (cnt_q != '0);
	assign out_valid = pop;
	assign full      = (cnt_q == (PTR_W+1)'(DEPTH));
	assign out_cx    = cx_q[rd_q];
	assign out_cy    = cy_q[rd_q];
	assign out_cz    = cz_q[rd_q];
	assign out_vis   = vis_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cx_q[wr_q]  <= in_cx;
			cy_q[wr_q]  <= in_cy;
			cz_q[wr_q]  <= in_cz;
			vis_q[wr_q] <= in_vis;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(DEPTH)) else $error("queue count out of range");
	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(1)) else $error("queue holds more than one entry");
`endif

endmodule

@@ sv/vtp_back.sv @@
`timescale 1ns / 1ps
module vtp_back
	import vtp_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] in_cx,
	input  logic signed [W-1:0] in_cy,
	input  logic signed [W-1:0] in_cz,
	input  logic                in_vis,
	input  logic [W-2:0]        view_dist,
	input  logic [W-2:0]        cen_x,
	input  logic [W-2:0]        cen_y,
	output logic                done,
	output logic signed [W-1:0] screen_x,
	output logic signed [W-1:0] screen_y,
	output logic signed [W-1:0] depth,
	output logic                visible
);

	localparam logic [W-1:0] CAP = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

	function automatic logic [W:0] div_step(logic [W-1:0] rem, logic bin, logic [W-1:0] z);
		logic [W:0] t;
		logic [W:0] d;
		t = {rem, bin};
		d = t - {1'b0, z};
		if (t >= {1'b0, z})
			return {1'b1, d[W-1:0]};
		return {1'b0, t[W-1:0]};
	endfunction

	function automatic logic signed [W-1:0] proj_fin(logic [W-1:0] q, logic sat,
		logic neg, logic [W-2:0] cen);
		logic [W-1:0] qc;
		logic signed [W:0] r;
		logic signed [W-1:0] rs;
		logic signed [W:0] t;
		qc = (sat || q > CAP) ? CAP : q;
		r  = neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
		rs = (!r[W] && r[W-1]) ? SMAX : r[W-1:0];
		t  = $signed({rs[W-1], rs}) + $signed({2'b00, cen});
		return (t[W] != t[W-1]) ? SMAX : t[W-1:0];
	endfunction

	logic [W-1:0] mag_x, mag_y;
	logic         neg_x, neg_y;

	always_comb begin
		mag_x = in_cx[W-1] ? W'(-in_cx) : W'(in_cx);
		mag_y = in_cy[W-1] ? W'(-in_cy) : W'(in_cy);
		neg_x = in_cx[W-1];
		neg_y = !in_cy[W-1] && (in_cy != '0);
	end

	ctl_t           ctl_s1;
	logic [2*W-1:0] pm_x_s1, pm_y_s1;
	logic [W-1:0]   z_s1;

	ctl_t         ctl_d [0:W];
	logic [W-1:0] rem_x_d [0:W];
	logic [W-1:0] rem_y_d [0:W];
	logic [W-1:0] lo_x_d [0:W];
	logic [W-1:0] lo_y_d [0:W];
	logic [W-1:0] qx_d [0:W];
	logic [W-1:0] qy_d [0:W];
	logic [W-1:0] z_d [0:W];
	logic [W:0]   step_x [W];
	logic [W:0]   step_y [W];

	for (genvar k = 0; k < W; k++) begin : g_div
		assign step_x[k] = div_step(rem_x_d[k], lo_x_d[k][W-1], z_d[k]);
		assign step_y[k] = div_step(rem_y_d[k], lo_y_d[k][W-1], z_d[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			for (int k = 0; k <= W; k++)
				ctl_d[k] <= '0;
		end else begin
			ctl_s1 <= '{vld: in_valid, vis: in_vis, negx: neg_x, negy: neg_y,
				satx: 1'b0, saty: 1'b0};
			ctl_d[0] <= '{vld: ctl_s1.vld, vis: ctl_s1.vis, negx: ctl_s1.negx,
				negy: ctl_s1.negy,
				satx: (pm_x_s1[2*W-1:W] >= z_s1),
				saty: (pm_y_s1[2*W-1:W] >= z_s1)};
			for (int k = 0; k < W; k++)
				ctl_d[k+1] <= ctl_d[k];
		end
	end

	always_ff @(posedge clk) begin
		pm_x_s1 <= (2*W)'(mag_x) * (2*W)'(view_dist);
		pm_y_s1 <= (2*W)'(mag_y) * (2*W)'(view_dist);
		z_s1    <= in_cz;

		rem_x_d[0] <= pm_x_s1[2*W-1:W];
		rem_y_d[0] <= pm_y_s1[2*W-1:W];
		lo_x_d[0]  <= pm_x_s1[W-1:0];
		lo_y_d[0]  <= pm_y_s1[W-1:0];
		qx_d[0]    <= '0;
		qy_d[0]    <= '0;
		z_d[0]     <= z_s1;

		for (int k = 0; k < W; k++) begin
			rem_x_d[k+1] <= step_x[k][W-1:0];
			rem_y_d[k+1] <= step_y[k][W-1:0];
			qx_d[k+1]    <= {qx_d[k][W-2:0], step_x[k][W]};
			qy_d[k+1]    <= {qy_d[k][W-2:0], step_y[k][W]};
			lo_x_d[k+1]  <= {lo_x_d[k][W-2:0], 1'b0};
			lo_y_d[k+1]  <= {lo_y_d[k][W-2:0], 1'b0};
			z_d[k+1]     <= z_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done     <= 1'b0;
			screen_x <= '0;
			screen_y <= '0;
			depth    <= '0;
			visible  <= 1'b0;
		end else begin
			done <= ctl_d[W].vld;
			if (ctl_d[W].vld && ctl_d[W].vis) begin
				screen_x <= proj_fin(qx_d[W], ctl_d[W].satx, ctl_d[W].negx, cen_x);
				screen_y <= proj_fin(qy_d[W], ctl_d[W].saty, ctl_d[W].negy, cen_y);
				depth    <= z_d[W];
				visible  <= 1'b1;
			end else begin
				screen_x <= '0;
				screen_y <= '0;
				depth    <= '0;
				visible  <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!visible |-> (screen_x == '0 && screen_y == '0 && depth == '0))
		else $error("hidden vertex with nonzero result");
	a_vis_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> done) else $error("visible without done");
	a_depth_pos: assert property (@(posedge clk) disable iff (!arst_n)
		visible |-> depth > 0) else $error("visible with nonpositive depth");
`endif

endmodule

@@ sv/vertex_transform_project.sv @@
`timescale 1ns / 1ps
// Vertex transform and perspective projection.
// Input: a vertex, its object's three angles and position, taken on an edge
// where start is high and busy is low. One transaction may enter every cycle.
// Output: done pulses for one cycle with screen_x, screen_y, depth, visible.
// Points at or behind the camera give zeros and visible low.
// Projection uses a restoring divider (one quotient bit per stage) in the back end.
// Throughput: one vertex per cycle; front transform (7 stages), a 4-entry
// queue and the projection pipeline all advance every cycle.
// Camera angles, view distance and screen center come from cfg_we/cfg_addr/
// cfg_wdata and may only change while no vertex is in flight.
// The receiver cannot stall; busy only rises if the queue were full.
// Reset clears the pipeline and loads camera angles 0, distance 200.0,
// center (320.0, 240.0).
module vertex_transform_project
	import vtp_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [ADDR_W-1:0]             cfg_addr,
	input  logic [COORD_WIDTH-2:0]        cfg_wdata,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_z,
	input  angle_t                        object_angle_x,
	input  angle_t                        object_angle_y,
	input  angle_t                        object_angle_z,
	input  logic signed [COORD_WIDTH-1:0] object_pos_x,
	input  logic signed [COORD_WIDTH-1:0] object_pos_y,
	input  logic signed [COORD_WIDTH-1:0] object_pos_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic signed [COORD_WIDTH-1:0] depth,
	output logic                          visible
);

	localparam int W = COORD_WIDTH;
	localparam logic [W-2:0] DIST_RST  = (W-1)'(64'd200 << FRAC_BITS);
	localparam logic [W-2:0] CEN_X_RST = (W-1)'(64'd320 << FRAC_BITS);
	localparam logic [W-2:0] CEN_Y_RST = (W-1)'(64'd240 << FRAC_BITS);

	angle_t       cam_x_q, cam_y_q, cam_z_q;
	logic [W-2:0] dist_q, cen_x_q, cen_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			dist_q  <= DIST_RST;
			cen_x_q <= CEN_X_RST;
			cen_y_q <= CEN_Y_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CAM_X: cam_x_q <= cfg_wdata[ANG_W-1:0];
				REG_CAM_Y: cam_y_q <= cfg_wdata[ANG_W-1:0];
				REG_CAM_Z: cam_z_q <= cfg_wdata[ANG_W-1:0];
				REG_DIST:  dist_q  <= cfg_wdata;
				REG_CEN_X: cen_x_q <= cfg_wdata;
				REG_CEN_Y: cen_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic                accept;
	logic                f_valid, f_vis;
	logic signed [W-1:0] f_cx, f_cy, f_cz;
	logic                q_valid, q_vis;
	logic signed [W-1:0] q_cx, q_cy, q_cz;

	assign accept = start && !busy;

	vtp_front #(.W(W)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (accept),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.vertex_z       (vertex_z),
		.object_angle_x (object_angle_x),
		.object_angle_y (object_angle_y),
		.object_angle_z (object_angle_z),
		.object_pos_x   (object_pos_x),
		.object_pos_y   (object_pos_y),
		.object_pos_z   (object_pos_z),
		.cam_x          (cam_x_q),
		.cam_y          (cam_y_q),
		.cam_z          (cam_z_q),
		.out_valid      (f_valid),
		.cx             (f_cx),
		.cy             (f_cy),
		.cz             (f_cz),
		.vis            (f_vis)
	);

	vtp_queue #(.W(W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.in_cx     (f_cx),
		.in_cy     (f_cy),
		.in_cz     (f_cz),
		.in_vis    (f_vis),
		.full      (busy),
		.out_valid (q_valid),
		.out_cx    (q_cx),
		.out_cy    (q_cy),
		.out_cz    (q_cz),
		.out_vis   (q_vis)
	);

	vtp_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_cx     (q_cx),
		.in_cy     (q_cy),
		.in_cz     (q_cz),
		.in_vis    (q_vis),
		.view_dist (dist_q),
		.cen_x     (cen_x_q),
		.cen_y     (cen_y_q),
		.done      (done),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.depth     (depth),
		.visible   (visible)
	);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import vtp_pkg::*;

	localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [ADDR_W-1:0] REG_SPARE  = 3'd6;
	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;
	localparam int DRAIN = 60;

	typedef longint mat3_t [3][3];

	typedef struct {
		logic signed [31:0] vx, vy, vz;
		angle_t ax, ay, az;
		logic signed [31:0] px, py, pz;
	} vertex_item_t;

	typedef struct {
		logic signed [31:0] sx, sy, dz;
		logic vis;
	} screen_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [30:0] cfg_wdata = '0;
	logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
	angle_t object_angle_x = '0, object_angle_y = '0, object_angle_z = '0;
	logic signed [31:0] object_pos_x = '0, object_pos_y = '0, object_pos_z = '0;
	logic done;
	logic signed [31:0] screen_x, screen_y, depth;
	logic visible;

	angle_t cam_ax = '0, cam_ay = '0, cam_az = '0;
	longint view_dist = 64'd13107200;
	longint cen_x = 64'd20971520;
	longint cen_y = 64'd15728640;

	screen_pt_t pending_pts[$];
	int errors = 0;
	bit idling_on = 1'b1;

	vertex_transform_project uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.object_angle_x(object_angle_x), .object_angle_y(object_angle_y),
		.object_angle_z(object_angle_z),
		.object_pos_x(object_pos_x), .object_pos_y(object_pos_y),
		.object_pos_z(object_pos_z),
		.done(done), .screen_x(screen_x), .screen_y(screen_y), .depth(depth),
		.visible(visible)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic longint sine_deg(angle_t a);
		int d;
		d = (a >= 360) ? a - 360 : a;
		if (d <= 90) return QSINE[d];
		if (d <= 180) return QSINE[180 - d];
		if (d <= 270) return -longint'(QSINE[d - 180]);
		return -longint'(QSINE[360 - d]);
	endfunction

	function automatic longint cosine_deg(angle_t a);
		int d;
		d = (a >= 360) ? a - 360 : a;
		return sine_deg(angle_t'((d + 90) % 360));
	endfunction

	function automatic longint rnd_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic mat3_t mat_prod(mat3_t a, mat3_t b);
		mat3_t c;
		longint s;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				s = 0;
				for (int k = 0; k < 3; k++) s += a[i][k] * b[k][j];
				c[i][j] = rnd_shift(s, TRIG_FRAC);
			end
		return c;
	endfunction

	// cam: camera order Rz*Ry*Rx with negated sines, else Rx*Ry*Rz
	function automatic mat3_t rotation(angle_t ax, angle_t ay, angle_t az, bit cam);
		mat3_t rx, ry, rz;
		longint sg;
		sg = cam ? -1 : 1;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				rx[i][j] = (i == j) ? 16384 : 0;
				ry[i][j] = rx[i][j];
				rz[i][j] = rx[i][j];
			end
		rx[1][1] = cosine_deg(ax); rx[2][2] = rx[1][1];
		rx[1][2] = sg * sine_deg(ax); rx[2][1] = -rx[1][2];
		ry[0][0] = cosine_deg(ay); ry[2][2] = ry[0][0];
		ry[2][0] = sg * sine_deg(ay); ry[0][2] = -ry[2][0];
		rz[0][0] = cosine_deg(az); rz[1][1] = rz[0][0];
		rz[0][1] = sg * sine_deg(az); rz[1][0] = -rz[0][1];
		if (cam) return mat_prod(mat_prod(rz, ry), rx);
		return mat_prod(mat_prod(rx, ry), rz);
	endfunction

	function automatic longint perspective(longint num, longint z, longint center);
		longint unsigned mag, q;
		longint r;
		mag = (num < 0) ? longint'(-num) : num;
		q = (mag * longint'(view_dist)) / longint'(z);
		if (q > 64'd2147483648) q = 64'd2147483648;
		r = (num < 0) ? -longint'(q) : longint'(q);
		return clamp32(clamp32(r) + center);
	endfunction

	function automatic screen_pt_t transform_vertex(vertex_item_t it);
		mat3_t om, vm;
		longint v[3], w[3], c[3], p[3];
		screen_pt_t r;
		om = rotation(it.ax, it.ay, it.az, 1'b0);
		vm = rotation(cam_ax, cam_ay, cam_az, 1'b1);
		v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
		p[0] = it.px; p[1] = it.py; p[2] = it.pz;
		for (int j = 0; j < 3; j++)
			w[j] = clamp32(rnd_shift(v[0] * om[0][j] + v[1] * om[1][j]
				+ v[2] * om[2][j], TRIG_FRAC) + p[j]);
		for (int j = 0; j < 3; j++)
			c[j] = clamp32(rnd_shift(w[0] * vm[0][j] + w[1] * vm[1][j]
				+ w[2] * vm[2][j], TRIG_FRAC));
		r = '{sx: 0, sy: 0, dz: 0, vis: 1'b0};
		if (c[2] > 0) begin
			r.sx = 32'(perspective(c[0], c[2], cen_x));
			r.sy = 32'(perspective(-c[1], c[2], cen_y));
			r.dz = 32'(c[2]);
			r.vis = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		screen_pt_t e;
		if (done) begin
			if (pending_pts.size() == 0) begin
				$display("%0t: unexpected transaction sx=%h sy=%h dz=%h vis=%b",
					$time, screen_x, screen_y, depth, visible);
				errors++;
			end else begin
				e = pending_pts.pop_front();
				if (screen_x !== e.sx) begin
					$display("%0t: screen_x exp %h got %h", $time, e.sx, screen_x);
					errors++;
				end
				if (screen_y !== e.sy) begin
					$display("%0t: screen_y exp %h got %h", $time, e.sy, screen_y);
					errors++;
				end
				if (depth !== e.dz) begin
					$display("%0t: depth exp %h got %h", $time, e.dz, depth);
					errors++;
				end
				if (visible !== e.vis) begin
					$display("%0t: visible exp %b got %b", $time, e.vis, visible);
					errors++;
				end
			end
		end
	end

	task automatic send_vertex(vertex_item_t it);
		while (idling_on && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		vertex_x <= it.vx; vertex_y <= it.vy; vertex_z <= it.vz;
		object_angle_x <= it.ax; object_angle_y <= it.ay; object_angle_z <= it.az;
		object_pos_x <= it.px; object_pos_y <= it.py; object_pos_z <= it.pz;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_pts.push_back(transform_vertex(it));
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] idx, logic [30:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAM_X: cam_ax = val[8:0];
			REG_CAM_Y: cam_ay = val[8:0];
			REG_CAM_Z: cam_az = val[8:0];
			REG_DIST:  view_dist = longint'(val);
			REG_CEN_X: cen_x = longint'(val);
			REG_CEN_Y: cen_y = longint'(val);
			default: ;
		endcase
	endtask

	function automatic vertex_item_t mk(longint vx, longint vy, longint vz,
			int ax, int ay, int az, longint px, longint py, longint pz);
		vertex_item_t it;
		it.vx = 32'(vx); it.vy = 32'(vy); it.vz = 32'(vz);
		it.ax = angle_t'(ax); it.ay = angle_t'(ay); it.az = angle_t'(az);
		it.px = 32'(px); it.py = 32'(py); it.pz = 32'(pz);
		return it;
	endfunction

	function automatic vertex_item_t rand_vertex();
		vertex_item_t it;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			it.vx = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			it.vy = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			it.vz = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			it.px = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
			it.py = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
			it.pz = $urandom_range(32'h0100_0000, 32'h1000_0000);
		end else begin
			it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
			it.px = $urandom; it.py = $urandom; it.pz = $urandom;
		end
		it.ax = angle_t'((mode == 9) ? $urandom_range(0, 511) : $urandom_range(0, 359));
		it.ay = angle_t'((mode == 9) ? $urandom_range(0, 511) : $urandom_range(0, 359));
		it.az = angle_t'((mode == 9) ? $urandom_range(0, 511) : $urandom_range(0, 359));
		return it;
	endfunction

	task automatic test_directed;
		send_vertex(mk(0, 0, 0, 0, 0, 0, 0, 0, 64'sh0001_0000));
		send_vertex(mk(64'sh0010_0000, 64'sh0020_0000, 0, 0, 0, 0, 0, 0, 64'sh0064_0000));
		send_vertex(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_vertex(mk(0, 0, 0, 0, 0, 0, 5, 7, -64'sd65536));
		send_vertex(mk(CMAX, CMAX, CMAX, 0, 0, 0, CMAX, CMAX, CMAX));
		send_vertex(mk(CMIN, CMIN, CMIN, 0, 0, 0, CMIN, CMIN, CMIN));
		send_vertex(mk(CMIN, CMIN, 64'sh0001_0000, 0, 0, 0, 0, 0, 1));
		send_vertex(mk(CMAX, CMIN, CMAX, 0, 0, 0, CMAX, CMIN, 1));
		send_vertex(mk(64'sh0010_0000, 64'sh0010_0000, 64'sh0010_0000, 90, 180, 270,
			0, 0, 64'sh0100_0000));
		send_vertex(mk(64'sh0010_0000, 64'sh0010_0000, 64'sh0010_0000, 359, 45, 30,
			0, 0, 64'sh0100_0000));
		send_vertex(mk(64'sh0010_0000, 64'sh0010_0000, 64'sh0010_0000, 360, 400, 511,
			0, 0, 64'sh0100_0000));
		send_vertex(mk(64'sh0010_0000, -64'sh0030_0000, 64'sh0020_0000, 271, 179, 91,
			64'sh0001_0000, -64'sh0001_0000, 64'sh0200_0000));
		send_vertex(mk(-1, -1, -1, 511, 511, 511, -1, -1, -1));
	endtask

	task automatic test_config_extremes;
		write_reg(REG_DIST, '0);
		send_vertex(mk(64'sh0010_0000, 64'sh0010_0000, 0, 0, 0, 0, 0, 0, 64'sh0010_0000));
		write_reg(REG_DIST, 31'h7FFF_FFFF);
		write_reg(REG_CEN_X, 31'h7FFF_FFFF);
		write_reg(REG_CEN_Y, '0);
		send_vertex(mk(64'sh0010_0000, -64'sh0010_0000, 0, 0, 0, 0, 0, 0, 1));
		send_vertex(mk(-64'sh0010_0000, 64'sh0010_0000, 0, 0, 0, 0, 0, 0, 1));
		send_vertex(mk(1, 1, 0, 0, 0, 0, 0, 0, CMAX));
		write_reg(REG_DIST, 31'd1);
		write_reg(REG_CAM_X, 31'd359);
		write_reg(REG_CAM_Y, 31'd360);
		write_reg(REG_CAM_Z, 31'd511);
		send_vertex(mk(64'sh0010_0000, 64'sh0020_0000, 64'sh0030_0000, 10, 20, 30,
			0, 0, 64'sh0400_0000));
		write_reg(REG_UNUSED, 31'h7FFF_FFFF);
		write_reg(REG_SPARE, 31'h1234_5678);
		send_vertex(mk(64'sh0010_0000, 64'sh0020_0000, 64'sh0030_0000, 10, 20, 30,
			0, 0, 64'sh0400_0000));
	endtask

	task automatic test_random;
		for (int phase = 0; phase < 5; phase++) begin
			write_reg(REG_CAM_X, 31'($urandom_range(0, 359)));
			write_reg(REG_CAM_Y, 31'($urandom_range(0, 359)));
			write_reg(REG_CAM_Z, 31'($urandom_range(0, phase == 4 ? 511 : 359)));
			write_reg(REG_DIST, 31'((phase == 0) ? 32'd13107200
				: $urandom_range(1, 32'h7FFF_FFFF)));
			write_reg(REG_CEN_X, 31'($urandom_range(0, 32'h7FFF_FFFF)));
			write_reg(REG_CEN_Y, 31'($urandom_range(0, 32'h7FFF_FFFF)));
			idling_on = (phase != 2);
			for (int n = 0; n < 100; n++) send_vertex(rand_vertex());
			idling_on = 1'b1;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		drain();
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
